### src/daic_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and reset constants for the dual-axis IIR compensator.
// No dependencies; every other file imports this package.
package daic_pkg;

	localparam int unsigned FILTER_ORDER_DEF = 3;
	localparam int unsigned MAX_ORDER        = 8;

	localparam int unsigned POS_W      = 16;
	localparam int unsigned ERR_W      = 17;
	localparam int unsigned COEF_W     = 24;
	localparam int unsigned ANG_W      = 32;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned PROD_W     = COEF_W + ANG_W;
	localparam int unsigned ACC_W      = 64;
	localparam int unsigned NUM_SHIFT  = 8;
	localparam int unsigned FRAC_SHIFT = 21;
	localparam int unsigned OQ_DEPTH   = 2;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [ANG_W-1:0]  ang_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef enum logic [1:0] {
		MODE_SAMPLE,
		MODE_TICK,
		MODE_START,
		MODE_STOP
	} mode_t;

	typedef struct packed {
		logic angles_valid;
		logic abort;
		logic running;
	} status_t;

	typedef struct packed {
		logic done;
		ang_t value;
	} lane_res_t;

	localparam ang_t ANG_MAX  = 32'sh7FFF_FFFF;
	localparam ang_t ANG_MIN  = 32'sh8000_0000;
	localparam acc_t RND_HALF = 64'sd1 <<< (FRAC_SHIFT - 1);

	localparam logic [31:0] LIMIT_RESET = 32'd671089;

	// numerator taps 0..MAX_ORDER, denominator taps 1..MAX_ORDER
	localparam coef_t NUM_RESET [MAX_ORDER+1] = '{
		-24'sd41608, -24'sd41817, 24'sd41230, 24'sd41419,
		24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0
	};
	localparam coef_t DEN_RESET [MAX_ORDER] = '{
		-24'sd5305795, 24'sd4475322, -24'sd1257872,
		24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0
	};

endpackage

### src/daic_lane.sv
`timescale 1ns / 1ps
// One axis of the compensator: error/output histories and a shared
// multiply-accumulate that walks the filter taps one product per cycle. Uses daic_pkg.
module daic_lane #(
	parameter int unsigned FILTER_ORDER = daic_pkg::FILTER_ORDER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  daic_pkg::err_t     err,
	input  daic_pkg::coef_t    num_coef [FILTER_ORDER+1],
	input  daic_pkg::coef_t    den_coef [FILTER_ORDER],
	output daic_pkg::lane_res_t res
);
	import daic_pkg::*;

	localparam int unsigned TERMS  = 2 * FILTER_ORDER + 1;
	localparam int unsigned IDX_W  = $clog2(TERMS);
	localparam int unsigned NUM_IW = $clog2(FILTER_ORDER + 1);
	localparam int unsigned DEN_IW = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;

	err_t             err_hist_q [FILTER_ORDER+1];
	ang_t             out_hist_q [FILTER_ORDER];
	logic [IDX_W-1:0] idx_q;
	logic             mac_act_q;
	logic             prod_vld_s1;
	logic             prod_last_s1;
	logic             prod_sub_s1;
	acc_t             prod_s1;
	acc_t             acc_q;
	logic             sum_vld_s2;
	logic             done_q;
	ang_t             res_q;

	logic                     is_num;
	logic [IDX_W-1:0]         den_idx;
	coef_t                    coef_sel;
	ang_t                     opnd_sel;
	logic signed [PROD_W-1:0] mul;
	acc_t                     mul_ext;
	acc_t                     rnd;
	acc_t                     shr;
	ang_t                     sat;

	// tap select: numerator taps first, then denominator taps
	always_comb begin
		is_num  = idx_q < IDX_W'(FILTER_ORDER + 1);
		den_idx = idx_q - IDX_W'(FILTER_ORDER + 1);
		if (is_num) begin
			coef_sel = num_coef[idx_q[NUM_IW-1:0]];
			opnd_sel = {{(ANG_W-ERR_W){err_hist_q[idx_q[NUM_IW-1:0]][ERR_W-1]}},
				err_hist_q[idx_q[NUM_IW-1:0]]};
		end else begin
			coef_sel = den_coef[den_idx[DEN_IW-1:0]];
			opnd_sel = out_hist_q[den_idx[DEN_IW-1:0]];
		end
		mul     = coef_sel * opnd_sel;
		mul_ext = {{(ACC_W-PROD_W){mul[PROD_W-1]}}, mul};
	end

	// round half up, floor shift, clamp to 32 bits
	always_comb begin
		rnd = acc_q + RND_HALF;
		shr = rnd >>> FRAC_SHIFT;
		if (!shr[ACC_W-1] && (|shr[ACC_W-2:ANG_W-1])) begin
			sat = ANG_MAX;
		end else if (shr[ACC_W-1] && !(&shr[ACC_W-2:ANG_W-1])) begin
			sat = ANG_MIN;
		end else begin
			sat = shr[ANG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FILTER_ORDER + 1; k++) err_hist_q[k] <= '0;
			for (int k = 0; k < FILTER_ORDER; k++) out_hist_q[k] <= '0;
			idx_q        <= '0;
			mac_act_q    <= 1'b0;
			prod_vld_s1  <= 1'b0;
			prod_last_s1 <= 1'b0;
			sum_vld_s2   <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (start) begin
				for (int k = FILTER_ORDER; k > 0; k--) err_hist_q[k] <= err_hist_q[k-1];
				err_hist_q[0] <= err;
				idx_q         <= '0;
				mac_act_q     <= 1'b1;
			end else if (mac_act_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IDX_W'(TERMS - 1)) begin
					mac_act_q <= 1'b0;
				end
			end
			prod_vld_s1  <= mac_act_q;
			prod_last_s1 <= mac_act_q && (idx_q == IDX_W'(TERMS - 1));
			sum_vld_s2   <= prod_vld_s1 && prod_last_s1;
			done_q       <= sum_vld_s2;
			if (sum_vld_s2) begin
				for (int k = FILTER_ORDER - 1; k > 0; k--) out_hist_q[k] <= out_hist_q[k-1];
				out_hist_q[0] <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_sub_s1 <= !is_num;
		prod_s1     <= is_num ? (mul_ext <<< NUM_SHIFT) : mul_ext;
		if (start) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= prod_sub_s1 ? (acc_q - prod_s1) : (acc_q + prod_s1);
		end
		if (sum_vld_s2) begin
			res_q <= sat;
		end
	end

	assign res.done  = done_q;
	assign res.value = res_q;

endmodule

### src/daic_merge.sv
`timescale 1ns / 1ps
// Merging stage: joins the two lane results with the item status and
// queues finished beats for the output channel. Uses daic_pkg.
module daic_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  daic_pkg::status_t push_st,
	input  daic_pkg::ang_t    lane_y_val,
	input  daic_pkg::ang_t    lane_z_val,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output daic_pkg::ang_t    angle_about_y,
	output daic_pkg::ang_t    angle_about_z,
	output daic_pkg::status_t out_st
);
	import daic_pkg::*;

	localparam int unsigned PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		ang_t    ay;
		ang_t    az;
		status_t st;
	} beat_t;

	beat_t            ent_q [OQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	beat_t            beat;
	logic             pop;

	// z lane drives the angle about y, y lane the angle about z
	always_comb begin
		beat.st = push_st;
		beat.ay = push_st.angles_valid ? lane_z_val : '0;
		beat.az = push_st.angles_valid ? lane_y_val : '0;
	end

	assign pop       = out_valid && out_ready;
	assign full      = cnt_q == CNT_W'(OQ_DEPTH);
	assign out_valid = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= beat;
		end
	end

	assign angle_about_y = ent_q[rd_ptr_q].ay;
	assign angle_about_z = ent_q[rd_ptr_q].az;
	assign out_st        = ent_q[rd_ptr_q].st;

endmodule

### src/dual_axis_iir_compensator.sv
`timescale 1ns / 1ps
// Dual-axis IIR compensator top: command decode, radius check, coefficient
// registers, two filter lanes and the merging output queue. Uses daic_pkg.
// Start/stop and idle samples are queued when accepted, running samples after their radius
// check, ticks once lane y is done; non-ticks give one beat/cycle when input is not held off.
// A radius check or a busy tick holds input off; each lane makes one product per cycle.
// Async active-low reset clears histories, flags and loads default coefficients.
module dual_axis_iir_compensator #(
	parameter int unsigned FILTER_ORDER = daic_pkg::FILTER_ORDER_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  daic_pkg::mode_t                        mode,
	input  daic_pkg::pos_t                         position_y,
	input  daic_pkg::pos_t                         position_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output daic_pkg::ang_t                         angle_about_y,
	output daic_pkg::ang_t                         angle_about_z,
	output logic                                   angles_valid,
	output logic                                   abort,
	output logic                                   running,
	input  logic                                   cfg_we,
	input  logic [$clog2(2*FILTER_ORDER+2)-1:0]    cfg_index,
	input  logic [daic_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import daic_pkg::*;

	localparam int unsigned CFG_IW = $clog2(2 * FILTER_ORDER + 2);
	localparam int unsigned NUM_IW = $clog2(FILTER_ORDER + 1);
	localparam int unsigned DEN_IW = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
	localparam int unsigned SQ_W   = 2 * POS_W;

	// register file: numerator taps, denominator taps, squared radius limit
	coef_t       num_coef_q [FILTER_ORDER+1];
	coef_t       den_coef_q [FILTER_ORDER];
	logic [31:0] limit_q;

	// block state
	logic        running_q;
	pos_t        latched_y_q;
	pos_t        latched_z_q;
	logic        tick_busy_q;

	// radius check pipeline
	logic            chk_s1;
	logic [SQ_W-1:0] sq_y_s1;
	logic [SQ_W-1:0] sq_z_s1;

	logic              accept;
	logic              tick_go;
	logic [CFG_IW-1:0] den_widx;
	logic signed [SQ_W-1:0] sq_y;
	logic signed [SQ_W-1:0] sq_z;
	logic [SQ_W-1:0]   sq_sum;
	logic              over;
	err_t              err_y;
	err_t              err_z;
	lane_res_t         lane_y_res;
	lane_res_t         lane_z_res;
	logic              q_full;
	logic              push;
	status_t           push_st;
	status_t           out_st;

	// Input waits only on an in-flight tick, the radius check cycle, or a full queue.
	assign in_ready = !tick_busy_q && !chk_s1 && !q_full;
	assign accept   = in_valid && in_ready;
	assign tick_go  = accept && (mode == MODE_TICK);

	// squares fit in 31 bits each, so their sum cannot wrap
	assign sq_y   = position_y * position_y;
	assign sq_z   = position_z * position_z;
	assign sq_sum = sq_y_s1 + sq_z_s1;
	assign over   = sq_sum > limit_q;

	// error = setpoint (zero) minus latched position, one bit wider
	assign err_y = -{latched_y_q[POS_W-1], latched_y_q};
	assign err_z = -{latched_z_q[POS_W-1], latched_z_q};

	assign den_widx = cfg_index - CFG_IW'(FILTER_ORDER + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FILTER_ORDER + 1; k++) num_coef_q[k] <= NUM_RESET[k];
			for (int k = 0; k < FILTER_ORDER; k++) den_coef_q[k] <= DEN_RESET[k];
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index <= CFG_IW'(FILTER_ORDER)) begin
				num_coef_q[cfg_index[NUM_IW-1:0]] <= cfg_data[COEF_W-1:0];
			end else if (cfg_index <= CFG_IW'(2 * FILTER_ORDER)) begin
				den_coef_q[den_widx[DEN_IW-1:0]] <= cfg_data[COEF_W-1:0];
			end else if (cfg_index == CFG_IW'(2 * FILTER_ORDER + 1)) begin
				limit_q <= cfg_data[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			latched_y_q <= '0;
			latched_z_q <= '0;
			tick_busy_q <= 1'b0;
			chk_s1      <= 1'b0;
		end else begin
			// a sample taken while running gets its radius check next cycle
			chk_s1 <= accept && (mode == MODE_SAMPLE) && running_q;
			if (accept) begin
				case (mode)
					MODE_SAMPLE: begin
						if (running_q) begin
							latched_y_q <= position_y;
							latched_z_q <= position_z;
						end
					end
					MODE_TICK:  tick_busy_q <= 1'b1;
					MODE_START: running_q   <= 1'b1;
					MODE_STOP:  running_q   <= 1'b0;
					default:    running_q   <= running_q;
				endcase
			end
			if (lane_y_res.done) begin
				tick_busy_q <= 1'b0;
			end
			if (chk_s1 && over) begin
				running_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_y_s1 <= sq_y;
		sq_z_s1 <= sq_z;
	end

	// One beat per item; the three sources never coincide since input is
	// held off during the radius check and during a tick.
	always_comb begin
		push    = 1'b0;
		push_st = '0;
		if (chk_s1) begin
			push            = 1'b1;
			push_st.abort   = over;
			push_st.running = !over;
		end else if (lane_y_res.done) begin
			push                 = 1'b1;
			push_st.angles_valid = 1'b1;
			push_st.running      = running_q;
		end else if (accept) begin
			case (mode)
				MODE_SAMPLE: begin
					push            = !running_q;
					push_st.running = running_q;
				end
				MODE_START: begin
					push            = 1'b1;
					push_st.running = 1'b1;
				end
				MODE_STOP: begin
					push            = 1'b1;
					push_st.running = 1'b0;
				end
				default: push = 1'b0;
			endcase
		end
	end

	daic_lane #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (tick_go),
		.err     (err_y),
		.num_coef(num_coef_q),
		.den_coef(den_coef_q),
		.res     (lane_y_res)
	);

	daic_lane #(
		.FILTER_ORDER(FILTER_ORDER)
	) u_lane_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (tick_go),
		.err     (err_z),
		.num_coef(num_coef_q),
		.den_coef(den_coef_q),
		.res     (lane_z_res)
	);

	daic_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_st      (push_st),
		.lane_y_val   (lane_y_res.value),
		.lane_z_val   (lane_z_res.value),
		.full         (q_full),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.angle_about_y(angle_about_y),
		.angle_about_z(angle_about_z),
		.out_st       (out_st)
	);

	assign angles_valid = out_st.angles_valid;
	assign abort        = out_st.abort;
	assign running      = out_st.running;

endmodule
